### rtl/core/tbl_pkg.sv
// ----------------------------------------------------------------------------
// tbl_pkg
// Shared types and constants of the tetrahedron barycentric locator.
// ----------------------------------------------------------------------------
package tbl_pkg;

    localparam int COORD_W = 32;
    localparam int DIFF_W  = 33;
    localparam int CROSS_W = 67;
    localparam int WIDE_W  = 101;
    localparam int MA_W    = 68;
    localparam int CFG_W   = 18;
    localparam int CORNER_WORDS = 12;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [1:0] REG_TET_COUNT = 2'd0;
    localparam logic [1:0] REG_LOWER     = 2'd1;
    localparam logic [1:0] REG_SUM_LIMIT = 2'd2;

    localparam logic [12:0]        RST_TET_COUNT = 13'd0;
    localparam logic signed [16:0] RST_LOWER     = -17'sd3277;
    localparam logic [17:0]        RST_SUM_LIMIT = 18'd72090;

    localparam logic signed [31:0] FALLBACK_QUARTER = 32'sd16384;
    localparam logic signed [31:0] FALLBACK_HALF    = 32'sd32768;
    localparam logic signed [31:0] LAMBDA_MAX       = 32'sh7fffffff;
    localparam logic signed [31:0] LAMBDA_MIN       = 32'sh80000000;

    typedef logic signed [WIDE_W-1:0] t_wide;

    typedef struct packed {
        logic               op;
        logic [11:0]        tet_slot;
        logic [1:0]         corner;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic signed [31:0] coord_z;
    } t_in;

    typedef struct packed {
        logic               found;
        logic [11:0]        tet_hit;
        logic signed [31:0] lambda_a;
        logic signed [31:0] lambda_b;
        logic signed [31:0] lambda_c;
    } t_out;

endpackage

### rtl/core/tbl_corner_mem.sv
// ----------------------------------------------------------------------------
// tbl_corner_mem
// Corner coordinate store, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module tbl_corner_mem
    import tbl_pkg::*;
#(
    parameter int DEPTH = 49152,
    parameter int AW    = 16
) (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [AW-1:0]      i_waddr,
    input  logic [COORD_W-1:0] i_wdata,
    input  logic [AW-1:0]      i_raddr,
    output logic [COORD_W-1:0] o_rdata
);

    logic [COORD_W-1:0] r_mem [DEPTH];
    logic [COORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/tbl_mul.sv
// ----------------------------------------------------------------------------
// tbl_mul
// Sequential signed multiplier, 68 x 33 bits, one 11-bit slice per cycle.
// ----------------------------------------------------------------------------
module tbl_mul
    import tbl_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [MA_W-1:0]   i_a,
    input  logic signed [DIFF_W-1:0] i_b,
    output logic                     o_done,
    output t_wide                    o_p
);

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_FIN} t_state;

    t_state              r_state;
    logic [MA_W-1:0]     r_ma;
    logic [DIFF_W-1:0]   r_mb;
    logic                r_neg;
    logic [1:0]          r_cnt;
    logic [WIDE_W-1:0]   r_acc;
    logic                r_done;
    t_wide               r_p;

    logic [10:0]         w_slice;
    logic [MA_W+10:0]    w_pp;
    logic [WIDE_W-1:0]   w_sh;

    always_comb begin
        case (r_cnt)
            2'd0:    w_slice = r_mb[10:0];
            2'd1:    w_slice = r_mb[21:11];
            default: w_slice = r_mb[32:22];
        endcase
        w_pp = r_ma * w_slice;
        case (r_cnt)
            2'd0:    w_sh = WIDE_W'(w_pp);
            2'd1:    w_sh = WIDE_W'(w_pp) << 11;
            default: w_sh = WIDE_W'(w_pp) << 22;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= (r_state == S_FIN);
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_ma    <= i_a[MA_W-1] ? MA_W'(-i_a) : MA_W'(i_a);
                        r_mb    <= i_b[DIFF_W-1] ? DIFF_W'(-i_b) : DIFF_W'(i_b);
                        r_neg   <= i_a[MA_W-1] ^ i_b[DIFF_W-1];
                        r_acc   <= '0;
                        r_cnt   <= 2'd0;
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    r_acc <= r_acc + w_sh;
                    r_cnt <= r_cnt + 2'd1;
                    if (r_cnt == 2'd2) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_p     <= r_neg ? -$signed(r_acc) : $signed(r_acc);
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_p    = r_p;

endmodule

### rtl/core/tbl_div.sv
// ----------------------------------------------------------------------------
// tbl_div
// Lambda divider: (num * 2^16) / det, truncated, saturated to 32 bits.
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tbl_div
    import tbl_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  t_wide              i_num,
    input  t_wide              i_det,
    output logic               o_done,
    output logic signed [31:0] o_lambda
);

    typedef enum logic [1:0] {S_IDLE, S_PREP, S_RUN, S_FIN} t_state;

    t_state              r_state;
    logic [WIDE_W-2:0]   r_nm;
    logic [WIDE_W-2:0]   r_dm;
    logic                r_neg;
    logic                r_sat;
    logic [WIDE_W-1:0]   r_rem;
    logic [31:0]         r_low;
    logic [31:0]         r_q;
    logic [4:0]          r_cnt;
    logic                r_done;
    logic signed [31:0]  r_lambda;

    logic [WIDE_W-1:0]   w_rem2;
    logic                w_ge;

    always_comb begin
        w_rem2 = {r_rem[WIDE_W-2:0], r_low[31]};
        w_ge   = (w_rem2 >= {1'b0, r_dm});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= (r_state == S_FIN);
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_nm    <= (WIDE_W-1)'(i_num[WIDE_W-1] ? -i_num : i_num);
                        r_dm    <= (WIDE_W-1)'(i_det[WIDE_W-1] ? -i_det : i_det);
                        r_neg   <= i_num[WIDE_W-1] ^ i_det[WIDE_W-1];
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_sat   <= ({16'd0, r_nm} >= {r_dm, 16'd0});
                    r_rem   <= WIDE_W'(r_nm >> 16);
                    r_low   <= {r_nm[15:0], 16'd0};
                    r_q     <= '0;
                    r_cnt   <= '0;
                    r_state <= S_RUN;
                end
                S_RUN: begin
                    r_rem   <= w_ge ? (w_rem2 - {1'b0, r_dm}) : w_rem2;
                    r_q     <= {r_q[30:0], w_ge};
                    r_low   <= {r_low[30:0], 1'b0};
                    r_cnt   <= r_cnt + 5'd1;
                    if (r_cnt == 5'd31) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (r_neg) begin
                        r_lambda <= (r_sat || r_q > 32'h80000000) ? LAMBDA_MIN
                                                                  : $signed(32'd0 - r_q);
                    end else begin
                        r_lambda <= (r_sat || r_q[31]) ? LAMBDA_MAX : $signed(r_q);
                    end
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_lambda = r_lambda;

endmodule

### rtl/core/tetrahedron_barycentric_locator.sv
// ----------------------------------------------------------------------------
// tetrahedron_barycentric_locator
// Stores tetrahedron corners and finds the first tetrahedron that holds a
// query point, returning its barycentric weights.
//
//   channel  direction  handshake                  payload
//   in       input      i_in_valid / o_in_ready    i_in  (t_in)
//   out      output     o_out_valid / i_out_ready  o_out (t_out)
//   cfg      input      i_cfg_we                   i_cfg_idx, i_cfg_data
//
// A load makes three memory writes. For each tetrahedron scanned, a query
// makes twelve memory reads, 30 products on the shared multiplier and three
// divisions; a tetrahedron with zero determinant ends after the 21 products
// of its determinant.
// No clearing pass after reset. A finished result waits in the output
// register while the next item is taken; a query stalls only at its end.
// ----------------------------------------------------------------------------
module tetrahedron_barycentric_locator
    import tbl_pkg::*;
#(
    parameter int MAX_TETS = 4096
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in              i_in,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out             o_out,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data
);

    localparam int DEPTH = MAX_TETS * CORNER_WORDS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int TCW   = $clog2(MAX_TETS + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_RD, S_RDW, S_MS, S_MW, S_DS, S_DW, S_CHK, S_NXT, S_FIN
    } t_state;

    t_state              r_state;
    t_in                 r_item;
    logic [12:0]         r_tet_count;
    logic signed [16:0]  r_lower;
    logic [17:0]         r_limit;
    logic [TCW-1:0]      r_t;
    logic [TCW-1:0]      r_n;
    logic [3:0]          r_k;
    logic                r_cap_v;
    logic [3:0]          r_cap_idx;
    logic signed [31:0]  r_coord [12];
    logic                r_ph;
    logic [1:0]          r_g;
    logic [1:0]          r_ck;
    logic                r_h;
    t_wide               r_acc;
    logic signed [CROSS_W-1:0] r_cross [9];
    t_wide               r_det;
    t_wide               r_num [3];
    logic [1:0]          r_dsel;
    logic signed [31:0]  r_lam [3];
    logic                r_hit;
    logic                r_out_valid;
    t_out                r_out;

    logic signed [DIFF_W-1:0] w_d [4][3];
    logic signed [31:0]  w_p [3];
    logic [1:0]          w_i1, w_i2, w_xv, w_yv, w_cg;
    logic [3:0]          w_xidx;
    logic signed [MA_W-1:0]   w_mul_a;
    logic signed [DIFF_W-1:0] w_mul_b;
    logic                w_mul_start, w_mul_done;
    t_wide               w_mul_p;
    logic                w_div_start, w_div_done;
    logic signed [31:0]  w_div_lam;
    t_wide               w_sum;
    logic [AW-1:0]       w_waddr, w_raddr;
    logic                w_we;
    logic [COORD_W-1:0]  w_wdata, w_rdata;
    logic [TCW-1:0]      w_lim;
    logic [TCW-1:0]      w_t1;
    logic signed [33:0]  w_lsum;
    logic signed [31:0]  w_lb;
    logic                w_match;
    logic                w_out_free;

    assign w_p[0] = r_item.coord_x;
    assign w_p[1] = r_item.coord_y;
    assign w_p[2] = r_item.coord_z;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            for (int v = 0; v < 3; v++) begin
                w_d[v][k] = DIFF_W'(r_coord[v*3+k]) - DIFF_W'(r_coord[9+k]);
            end
            w_d[3][k] = DIFF_W'(w_p[k]) - DIFF_W'(r_coord[9+k]);
        end
    end

    always_comb begin
        case (r_ck)
            2'd0:    begin w_i1 = 2'd1; w_i2 = 2'd2; end
            2'd1:    begin w_i1 = 2'd2; w_i2 = 2'd0; end
            default: begin w_i1 = 2'd0; w_i2 = 2'd1; end
        endcase
        case (r_g)
            2'd0:    begin w_xv = 2'd1; w_yv = 2'd2; end
            2'd1:    begin w_xv = 2'd2; w_yv = 2'd0; end
            default: begin w_xv = 2'd0; w_yv = 2'd1; end
        endcase
        w_cg   = (r_g == 2'd0) ? 2'd0 : r_g - 2'd1;
        w_xidx = {2'd0, (r_ph ? w_cg : r_g)} * 4'd3 + {2'd0, r_ck};
        if (!r_ph) begin
            w_mul_a = MA_W'(r_h ? w_d[w_xv][w_i2] : w_d[w_xv][w_i1]);
            w_mul_b = r_h ? w_d[w_yv][w_i1] : w_d[w_yv][w_i2];
        end else begin
            w_mul_a = MA_W'(r_cross[w_xidx]);
            w_mul_b = (r_g == 2'd0) ? w_d[0][r_ck] : w_d[3][r_ck];
        end
        w_sum = (r_ck == 2'd0) ? w_mul_p : r_acc + w_mul_p;
    end

    always_comb begin
        w_lim = (32'(i_in.op == OP_QUERY ? r_tet_count : 13'd0) < MAX_TETS)
              ? TCW'(r_tet_count) : TCW'(MAX_TETS);
        w_t1  = r_t + TCW'(1);
        w_lb  = 32'(r_lower);
        w_lsum = 34'(r_lam[0]) + 34'(r_lam[1]) + 34'(r_lam[2]);
        w_match = (r_lam[0] > w_lb) && (r_lam[1] > w_lb) && (r_lam[2] > w_lb)
               && (w_lsum < $signed({16'd0, r_limit}));
        w_out_free = !r_out_valid || i_out_ready;
    end

    always_comb begin
        w_we    = (r_state == S_LOAD) && (32'(r_item.tet_slot) < MAX_TETS);
        w_waddr = AW'(AW'(r_item.tet_slot) * AW'(CORNER_WORDS))
                + AW'({r_item.corner, 1'b0}) + AW'(r_item.corner) + AW'(r_k[1:0]);
        case (r_k[1:0])
            2'd0:    w_wdata = r_item.coord_x;
            2'd1:    w_wdata = r_item.coord_y;
            default: w_wdata = r_item.coord_z;
        endcase
        w_raddr = AW'(AW'(r_t) * AW'(CORNER_WORDS)) + AW'(r_k);
        w_mul_start = (r_state == S_MS);
        w_div_start = (r_state == S_DS);
    end

    tbl_corner_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    tbl_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_done  (w_mul_done),
        .o_p     (w_mul_p)
    );

    tbl_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_div_start),
        .i_num    (r_num[r_dsel]),
        .i_det    (r_det),
        .o_done   (w_div_done),
        .o_lambda (w_div_lam)
    );

    always_ff @(posedge i_clk) begin
        if (r_cap_v) begin
            r_coord[r_cap_idx] <= signed'(w_rdata);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tet_count <= RST_TET_COUNT;
            r_lower     <= RST_LOWER;
            r_limit     <= RST_SUM_LIMIT;
            r_cap_v     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_TET_COUNT: r_tet_count <= i_cfg_data[12:0];
                    REG_LOWER:     r_lower     <= signed'(i_cfg_data[16:0]);
                    REG_SUM_LIMIT: r_limit     <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_out_valid && i_out_ready && r_state != S_FIN) begin
                r_out_valid <= 1'b0;
            end
            r_cap_v   <= (r_state == S_RD);
            r_cap_idx <= r_k;
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_item <= i_in;
                        r_k    <= '0;
                        r_t    <= '0;
                        r_n    <= w_lim;
                        r_hit  <= 1'b0;
                        if (i_in.op == OP_LOAD) begin
                            r_state <= S_LOAD;
                        end else if (w_lim == '0) begin
                            r_state <= S_FIN;
                        end else begin
                            r_state <= S_RD;
                        end
                    end
                end
                S_LOAD: begin
                    r_k <= r_k + 4'd1;
                    if (r_k == 4'd2) begin
                        r_state <= S_IDLE;
                    end
                end
                S_RD: begin
                    r_k <= r_k + 4'd1;
                    if (r_k == 4'd11) begin
                        r_state <= S_RDW;
                    end
                end
                S_RDW: begin
                    r_ph    <= 1'b0;
                    r_g     <= '0;
                    r_ck    <= '0;
                    r_h     <= 1'b0;
                    r_state <= S_MS;
                end
                S_MS: begin
                    r_state <= S_MW;
                end
                S_MW: begin
                    if (w_mul_done) begin
                        if (!r_ph) begin
                            r_state <= S_MS;
                            if (!r_h) begin
                                r_acc <= w_mul_p;
                                r_h   <= 1'b1;
                            end else begin
                                r_cross[w_xidx] <= CROSS_W'(r_acc - w_mul_p);
                                r_h <= 1'b0;
                                if (r_ck == 2'd2) begin
                                    r_ck <= '0;
                                    if (r_g == 2'd2) begin
                                        r_g  <= '0;
                                        r_ph <= 1'b1;
                                    end else begin
                                        r_g <= r_g + 2'd1;
                                    end
                                end else begin
                                    r_ck <= r_ck + 2'd1;
                                end
                            end
                        end else begin
                            r_acc <= w_sum;
                            if (r_ck == 2'd2) begin
                                r_ck <= '0;
                                if (r_g == 2'd0) begin
                                    r_det <= w_sum;
                                end else begin
                                    r_num[w_cg] <= w_sum;
                                end
                                if (r_g == 2'd0 && w_sum == '0) begin
                                    r_state <= S_NXT;
                                end else if (r_g == 2'd3) begin
                                    r_dsel  <= '0;
                                    r_state <= S_DS;
                                end else begin
                                    r_g     <= r_g + 2'd1;
                                    r_state <= S_MS;
                                end
                            end else begin
                                r_ck    <= r_ck + 2'd1;
                                r_state <= S_MS;
                            end
                        end
                    end
                end
                S_DS: begin
                    r_state <= S_DW;
                end
                S_DW: begin
                    if (w_div_done) begin
                        r_lam[r_dsel] <= w_div_lam;
                        if (r_dsel == 2'd2) begin
                            r_state <= S_CHK;
                        end else begin
                            r_dsel  <= r_dsel + 2'd1;
                            r_state <= S_DS;
                        end
                    end
                end
                S_CHK: begin
                    if (w_match) begin
                        r_hit   <= 1'b1;
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_NXT;
                    end
                end
                S_NXT: begin
                    r_k <= '0;
                    if (w_t1 == r_n) begin
                        r_state <= S_FIN;
                    end else begin
                        r_t     <= w_t1;
                        r_state <= S_RD;
                    end
                end
                S_FIN: begin
                    if (w_out_free) begin
                        r_out_valid   <= 1'b1;
                        r_out.found   <= r_hit;
                        r_out.tet_hit <= r_hit ? 12'(r_t) : 12'd0;
                        r_out.lambda_a <= r_hit ? r_lam[0] : FALLBACK_QUARTER;
                        r_out.lambda_b <= r_hit ? r_lam[1] : FALLBACK_QUARTER;
                        r_out.lambda_c <= r_hit ? r_lam[2] : FALLBACK_HALF;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
